// ===== hdl/eipm_pkg.sv =====
// Shared types and constants of the event interval performance monitor.
// Holds request codes, status codes and fixed field widths.
// No dependencies.
package eipm_pkg;

    // Fixed field widths.
    localparam int REQ_W  = 2;
    localparam int EV_W   = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 32;
    localparam int TOT_W  = 64;
    localparam int MASK_W = 8;

    // Width of the shared arithmetic unit operands.
    localparam int ALU_W  = 64;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [STAT_W-1:0] status_t;

    // Request codes.
    localparam req_t REQ_RECORD = 2'd0;
    localparam req_t REQ_READ   = 2'd1;
    localparam req_t REQ_CLEAR  = 2'd2;

    // Status codes.
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_DISCARD = 2'd1;
    localparam status_t ST_RANGE   = 2'd2;

endpackage

// ===== hdl/event_interval_perf_monitor_unit.sv =====
// Top level of the event interval performance monitor.
// Depends on eipm_pkg for request and status codes and field widths.
//
// Per-event counters with interval statistics. A record word raises the
// count of its event and credits the time since the stored stamp to the event
// recorded before it (total, minimum, maximum) when that event is timed; a zero
// interval discards the record. A read word returns one event's statistics, and
// a clear word wipes all statistics on acceptance. The block takes one word at
// a time. A record word with a timed previous event steps through fetch, total,
// minimum, maximum, count and done, a zero-interval discard and a read through
// fetch, total and done, an untimed record through fetch, total, count and done,
// and clear, unknown requests and out-of-range indexes go straight to done. The
// next word is taken in the cycle after the result is loaded. A stalled result
// channel holds the sequencer in its last step until the output register frees
// up. These steps are set by the single shared 64-bit add/subtract unit, which
// in turn forms the interval, the saturating total, the minimum and maximum
// compares and the count increment, and by the registered read of the statistics
// memories. A finished result waits in the output register while the next word
// is accepted and worked on. After reset the tables read as cleared at once.
module event_interval_perf_monitor_unit
    import eipm_pkg::*;
#(
    parameter int NUM_EVENTS = 8,
    parameter int TIME_WIDTH = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration
    input  logic                  timed_mask_we,
    input  logic [MASK_W-1:0]     timed_mask_wdata,
    // Request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [EV_W-1:0]       event_index,
    input  logic [TIME_WIDTH-1:0] timestamp,
    // Result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STAT_W-1:0]     status,
    output logic [CNT_W-1:0]      event_count,
    output logic [TOT_W-1:0]      total_time,
    output logic [TIME_WIDTH-1:0] min_time,
    output logic [TIME_WIDTH-1:0] max_time
);

    localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int ST_W  = 3;

    // Sequencer states.
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_FETCH = 3'd1;
    localparam logic [ST_W-1:0] S_TOTAL = 3'd2;
    localparam logic [ST_W-1:0] S_MIN   = 3'd3;
    localparam logic [ST_W-1:0] S_MAX   = 3'd4;
    localparam logic [ST_W-1:0] S_COUNT = 3'd5;
    localparam logic [ST_W-1:0] S_DONE  = 3'd6;

    localparam int SM_W = TOT_W + 2 * TIME_WIDTH;

    // Convert an event number to a table address.
    function automatic logic [IDX_W-1:0] ev_to_idx(input logic [EV_W-1:0] ev);
        logic [IDX_W+EV_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, ev};
        return wide[IDX_W-1:0];
    endfunction

    // True when the event number names an existing event.
    function automatic logic ev_in_range(input logic [EV_W-1:0] ev);
        return 32'(ev) < 32'(NUM_EVENTS);
    endfunction

    logic [ST_W-1:0]       state_reg, state_next;
    logic [MASK_W-1:0]     timed_mask_reg;

    // Captured request word.
    req_t                  req_reg;
    logic [EV_W-1:0]       ev_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    // Last-event record.
    logic                  last_valid_reg;
    logic [EV_W-1:0]       last_num_reg;
    logic [TIME_WIDTH-1:0] last_stamp_reg;

    // Working registers of the sequencer.
    logic [TIME_WIDTH-1:0] interval_reg;
    logic [TOT_W-1:0]      tot_new_reg;
    logic [TIME_WIDTH-1:0] min_new_reg;

    // Pending result.
    status_t               res_status_reg;
    logic [CNT_W-1:0]      res_count_reg;
    logic [TOT_W-1:0]      res_total_reg;
    logic [TIME_WIDTH-1:0] res_min_reg;
    logic [TIME_WIDTH-1:0] res_max_reg;

    // Output register.
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [CNT_W-1:0]      count_out_reg;
    logic [TOT_W-1:0]      total_out_reg;
    logic [TIME_WIDTH-1:0] min_out_reg;
    logic [TIME_WIDTH-1:0] max_out_reg;

    // Statistic memories with per-entry valid bits.
    logic [CNT_W-1:0]      count_mem [NUM_EVENTS];
    logic [SM_W-1:0]       stat_mem  [NUM_EVENTS];
    logic [NUM_EVENTS-1:0] cnt_vld_reg;
    logic [NUM_EVENTS-1:0] stat_vld_reg;
    logic [CNT_W-1:0]      cnt_rd_reg;
    logic [SM_W-1:0]       stat_rd_reg;
    logic                  cnt_rd_vld_reg;
    logic                  stat_rd_vld_reg;

    logic                  accept;
    logic                  out_load;
    logic                  timed_prev;
    logic [IDX_W-1:0]      ev_idx;
    logic [IDX_W-1:0]      prev_idx;
    logic [IDX_W-1:0]      stat_raddr;
    logic [CNT_W-1:0]      cnt_eff;
    logic [TOT_W-1:0]      tot_eff;
    logic [TIME_WIDTH-1:0] min_eff;
    logic [TIME_WIDTH-1:0] max_eff;
    logic                  stat_we;
    logic                  cnt_we;

    // Shared add/subtract unit.
    logic [ALU_W-1:0]      alu_a;
    logic [ALU_W-1:0]      alu_b;
    logic                  alu_sub;
    logic [ALU_W:0]        alu_sum;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign ev_idx     = ev_to_idx(ev_reg);
    assign prev_idx   = ev_to_idx(last_num_reg);
    assign timed_prev = last_valid_reg && ev_in_range(last_num_reg)
                        && timed_mask_reg[last_num_reg];
    assign stat_raddr = (req_reg == REQ_RECORD) ? prev_idx : ev_idx;

    // Entries never written since the last clear read as their reset values.
    assign cnt_eff = cnt_rd_vld_reg ? cnt_rd_reg : '0;
    assign tot_eff = stat_rd_vld_reg ? stat_rd_reg[SM_W-1 -: TOT_W] : '0;
    assign min_eff = stat_rd_vld_reg ? stat_rd_reg[2*TIME_WIDTH-1 -: TIME_WIDTH]
                                     : '1;
    assign max_eff = stat_rd_vld_reg ? stat_rd_reg[TIME_WIDTH-1:0] : '0;

    // Operand selection for the shared unit, one use per sequencer step.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_FETCH:
            begin
                alu_a   = ALU_W'(now_reg);
                alu_b   = ALU_W'(last_stamp_reg);
                alu_sub = 1'b1;
            end
            S_TOTAL:
            begin
                alu_a   = ALU_W'(tot_eff);
                alu_b   = ALU_W'(interval_reg);
            end
            S_MIN:
            begin
                alu_a   = ALU_W'(interval_reg);
                alu_b   = ALU_W'(min_eff);
                alu_sub = 1'b1;
            end
            S_MAX:
            begin
                alu_a   = ALU_W'(max_eff);
                alu_b   = ALU_W'(interval_reg);
                alu_sub = 1'b1;
            end
            S_COUNT:
            begin
                alu_a   = ALU_W'(cnt_eff);
                alu_b   = ALU_W'(1);
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}}
                     + {{ALU_W{1'b0}}, alu_sub};

    // Table writes happen at the end of the prior-event update and the count step.
    assign stat_we = (state_reg == S_MAX);
    assign cnt_we  = (state_reg == S_COUNT);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_type == REQ_RECORD || req_type == REQ_READ)
                        && ev_in_range(event_index))
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                priority if (req_reg != REQ_RECORD)
                    state_next = S_DONE;
                else if (!timed_prev)
                    state_next = S_COUNT;
                else if (interval_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_MIN;
            end
            S_MIN:
            begin
                state_next = S_MAX;
            end
            S_MAX:
            begin
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, last-event record, valid bits and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            timed_mask_reg <= '1;
            last_valid_reg <= 1'b0;
            last_num_reg   <= '0;
            last_stamp_reg <= '0;
            cnt_vld_reg    <= '0;
            stat_vld_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (timed_mask_we)
                timed_mask_reg <= timed_mask_wdata;

            // A clear forgets the last event and empties every table entry.
            if (accept && req_type == REQ_CLEAR)
            begin
                last_valid_reg <= 1'b0;
                last_num_reg   <= '0;
                cnt_vld_reg    <= '0;
                stat_vld_reg   <= '0;
            end

            if (stat_we)
                stat_vld_reg[prev_idx] <= 1'b1;

            if (cnt_we)
            begin
                cnt_vld_reg[ev_idx] <= 1'b1;
                last_valid_reg      <= 1'b1;
                last_num_reg        <= ev_reg;
                if (timed_mask_reg[ev_reg])
                    last_stamp_reg <= now_reg;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Memories: registered reads every cycle, writes from the sequencer.
    always_ff @(posedge clk)
    begin
        cnt_rd_reg  <= count_mem[ev_idx];
        stat_rd_reg <= stat_mem[stat_raddr];
        if (cnt_we)
            count_mem[ev_idx] <= (&cnt_eff) ? cnt_eff : alu_sum[CNT_W-1:0];
        if (stat_we)
            stat_mem[prev_idx] <= {tot_new_reg, min_new_reg,
                                   alu_sum[ALU_W] ? max_eff : interval_reg};
    end

    // Valid bits sampled along with the memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_rd_vld_reg  <= 1'b0;
            stat_rd_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_rd_vld_reg  <= cnt_vld_reg[ev_idx];
            stat_rd_vld_reg <= stat_vld_reg[stat_raddr];
        end
    end

    // Datapath registers: captured word, working values, pending result, output.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg        <= req_type;
            ev_reg         <= event_index;
            now_reg        <= timestamp;
            res_status_reg <= ((req_type == REQ_RECORD || req_type == REQ_READ)
                               && !ev_in_range(event_index)) ? ST_RANGE : ST_OK;
            res_count_reg  <= '0;
            res_total_reg  <= '0;
            res_min_reg    <= '0;
            res_max_reg    <= '0;
        end

        unique case (state_reg)
            S_FETCH:
            begin
                interval_reg <= alu_sum[TIME_WIDTH-1:0];
            end
            S_TOTAL:
            begin
                // A carry out of the total saturates it.
                tot_new_reg <= alu_sum[ALU_W] ? '1 : alu_sum[TOT_W-1:0];
                if (req_reg != REQ_RECORD)
                begin
                    res_count_reg <= cnt_eff;
                    res_total_reg <= tot_eff;
                    res_min_reg   <= min_eff;
                    res_max_reg   <= max_eff;
                end
                else if (timed_prev && interval_reg == '0)
                begin
                    res_status_reg <= ST_DISCARD;
                end
            end
            S_MIN:
            begin
                // A borrow means the interval is below the stored minimum.
                min_new_reg <= alu_sum[ALU_W] ? min_eff : interval_reg;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            status_reg    <= res_status_reg;
            count_out_reg <= res_count_reg;
            total_out_reg <= res_total_reg;
            min_out_reg   <= res_min_reg;
            max_out_reg   <= res_max_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign event_count = count_out_reg;
    assign total_time  = total_out_reg;
    assign min_time    = min_out_reg;
    assign max_time    = max_out_reg;

`ifndef SYNTHESIS
    // One word at a time: no new word is taken right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("word accepted while the previous one is in work");

    // Interval statistics are only written for a known timed previous event.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_we |-> (timed_prev && interval_reg != '0))
        else $error("statistics written without a timed previous event");

    // The last-event record always names an existing event.
    assert property (@(posedge clk) disable iff (!rst_n)
        last_valid_reg |-> ev_in_range(last_num_reg))
        else $error("last event number out of range");

    // Results other than ok carry no statistics.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |->
            (count_out_reg == '0 && total_out_reg == '0 && max_out_reg == '0))
        else $error("error result carries statistics");
`endif

endmodule
